>>> rtl/line_color_gradient_stepper_core_macros.svh
// Assertion macros shared by the gradient stepper RTL.
`ifndef LINE_COLOR_GRADIENT_STEPPER_CORE_MACROS_SVH
`define LINE_COLOR_GRADIENT_STEPPER_CORE_MACROS_SVH

// Invariant that must hold on every clock edge out of reset.
`define LCGS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define LCGS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LCGS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lcgs_pkg.sv
// Shared constants and types for the line color gradient stepper.
package lcgs_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CHAN_BITS      = 8;
  localparam int NUM_CHAN       = 3;
  localparam int COLOR_BITS     = CHAN_BITS * NUM_CHAN;
  localparam int STEP_W         = $clog2(CHAN_BITS);

  // Handshake status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

>>> rtl/lcgs_mul.sv
// Bit-serial shift-add multiplier: channel delta times step count.
module lcgs_mul import lcgs_pkg::*; #(
  parameter int LEN_BITS = COORD_BITS_DEF + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [LEN_BITS-1:0]           mcand,
  input  logic [CHAN_BITS-1:0]          mplier,
  output logic [LEN_BITS+CHAN_BITS-1:0] product,
  output unit_status_t                  status
);

  localparam int PW = LEN_BITS + CHAN_BITS;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CHAN_BITS-1:0] mplier_r;
  logic [LEN_BITS-1:0]  mcand_r;
  logic [PW-1:0]        acc_r;
  logic [PW-1:0]        acc_nxt;
  logic                 last_step;

  // MSB first: shift the partial sum, add the multiplicand when the bit is set
  always_comb begin
    acc_nxt = {acc_r[PW-2:0], 1'b0};
    if (mplier_r[CHAN_BITS-1]) begin
      acc_nxt = acc_nxt + {{CHAN_BITS{1'b0}}, mcand_r};
    end
  end

  assign last_step = (step_r == STEP_W'(CHAN_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !start && busy_r && last_step;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mplier_r <= mplier;
      mcand_r  <= mcand;
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      mplier_r <= {mplier_r[CHAN_BITS-2:0], 1'b0};
    end
  end

  assign product     = acc_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

>>> rtl/lcgs_div.sv
// Bit-serial restoring divider producing an eight-bit quotient.
module lcgs_div import lcgs_pkg::*; #(
  parameter int LEN_BITS = COORD_BITS_DEF + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [LEN_BITS+CHAN_BITS-1:0] dividend,
  input  logic [LEN_BITS-1:0]           divisor,
  output logic [CHAN_BITS-1:0]          quot,
  output unit_status_t                  status
);

  logic                 busy_r;
  logic                 done_r;
  logic [STEP_W-1:0]    step_r;
  logic [LEN_BITS-1:0]  rem_r;
  logic [LEN_BITS-1:0]  rem_nxt;
  logic [LEN_BITS-1:0]  divisor_r;
  logic [CHAN_BITS-1:0] low_r;
  logic [CHAN_BITS-1:0] quot_r;
  logic [LEN_BITS:0]    trial;
  logic [LEN_BITS:0]    diff;
  logic                 qbit;
  logic                 last_step;

  // Dividend is below 256 * divisor, so its upper part already fits under the divisor
  always_comb begin
    trial   = {rem_r, low_r[CHAN_BITS-1]};
    diff    = trial - {1'b0, divisor_r};
    qbit    = (trial >= {1'b0, divisor_r});
    rem_nxt = qbit ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
  end

  assign last_step = (step_r == STEP_W'(CHAN_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !start && busy_r && last_step;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= dividend[LEN_BITS+CHAN_BITS-1:CHAN_BITS];
      low_r     <= dividend[CHAN_BITS-1:0];
      divisor_r <= divisor;
      quot_r    <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      low_r  <= {low_r[CHAN_BITS-2:0], 1'b0};
      quot_r <= {quot_r[CHAN_BITS-2:0], qbit};
    end
  end

  assign quot        = quot_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

>>> rtl/line_color_gradient_stepper_core.sv
// Line color gradient stepper: per-pixel linear RGB interpolation along a line.
// A start item (kind = 1) latches the Manhattan length of the line and both
// colors and returns the start color through the output register. A step
// item (kind = 0) returns start + (end - start) * count / length for red,
// green and blue in turn, with the quotient truncated toward zero, then
// advances the count, which stops at the length. Each channel runs through a
// bit-serial multiplier and a bit-serial restoring divider, each entered
// through an issue state and a wait state, and then through the combine
// state; a step on a zero-length line bypasses both units and returns the
// start color. The next item is taken as soon as the result sits in the
// output register, even if that result has not yet been transferred.
`include "line_color_gradient_stepper_core_macros.svh"

module line_color_gradient_stepper_core import lcgs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COLOR_BITS-1:0] in_start_color,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  input  logic [COLOR_BITS-1:0] in_end_color,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COLOR_BITS-1:0] out_pixel_color
);

  localparam int LEN_BITS = COORD_BITS + 1;
  localparam int PW       = LEN_BITS + CHAN_BITS;
  localparam int CH_W     = $clog2(NUM_CHAN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MUL_WAIT,
    S_DIV,
    S_DIV_WAIT,
    S_ACC,
    S_DONE
  } state_t;

  state_t                state_r;
  logic [CH_W-1:0]       ch_r;
  logic [LEN_BITS-1:0]   step_count_r;
  logic [LEN_BITS-1:0]   line_length_r;
  logic [COLOR_BITS-1:0] start_color_r;
  logic [COLOR_BITS-1:0] end_color_r;
  logic [COLOR_BITS-1:0] result_r;
  logic [COLOR_BITS-1:0] out_pixel_color_r;
  logic                  out_valid_r;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [LEN_BITS-1:0]   length_nxt;
  logic [CHAN_BITS-1:0]  s_byte;
  logic [CHAN_BITS-1:0]  e_byte;
  logic                  neg;
  logic [CHAN_BITS-1:0]  mag;
  logic [CHAN_BITS-1:0]  chan_nxt;

  logic                  in_xfer;
  logic                  out_load;
  logic                  zero_len_step;
  logic                  mul_start;
  logic                  div_start;
  logic [PW-1:0]         product;
  logic [CHAN_BITS-1:0]  quot;
  unit_status_t          mul_st;
  unit_status_t          div_st;

  assign in_ready      = (state_r == S_IDLE);
  assign in_xfer       = in_valid && in_ready;
  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign zero_len_step = in_xfer && !in_kind && (line_length_r == '0);
  assign mul_start     = (state_r == S_MUL);
  assign div_start     = (state_r == S_DIV);

  always_comb begin
    dx         = (in_start_x > in_end_x) ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
    dy         = (in_start_y > in_end_y) ? (in_start_y - in_end_y) : (in_end_y - in_start_y);
    length_nxt = {1'b0, dx} + {1'b0, dy};
  end

  // Current channel always sits in the top byte; the color words rotate per channel
  always_comb begin
    s_byte   = start_color_r[COLOR_BITS-1 -: CHAN_BITS];
    e_byte   = end_color_r[COLOR_BITS-1 -: CHAN_BITS];
    neg      = (e_byte < s_byte);
    mag      = neg ? (s_byte - e_byte) : (e_byte - s_byte);
    chan_nxt = neg ? (s_byte - quot) : (s_byte + quot);
  end

  lcgs_mul #(.LEN_BITS(LEN_BITS)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (step_count_r),
    .mplier  (mag),
    .product (product),
    .status  (mul_st)
  );

  lcgs_div #(.LEN_BITS(LEN_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (line_length_r),
    .quot     (quot),
    .status   (div_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      ch_r              <= '0;
      step_count_r      <= '0;
      line_length_r     <= '0;
      start_color_r     <= '0;
      end_color_r       <= '0;
      result_r          <= '0;
      out_pixel_color_r <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_kind) begin
              line_length_r <= length_nxt;
              step_count_r  <= '0;
              start_color_r <= in_start_color;
              end_color_r   <= in_end_color;
              result_r      <= in_start_color;
              state_r       <= S_DONE;
            end else if (line_length_r == '0) begin
              result_r <= start_color_r;
              state_r  <= S_DONE;
            end else begin
              ch_r    <= '0;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state_r <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_st.done) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_st.done) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          result_r      <= {result_r[COLOR_BITS-CHAN_BITS-1:0], chan_nxt};
          start_color_r <= {start_color_r[COLOR_BITS-CHAN_BITS-1:0],
                            start_color_r[COLOR_BITS-1 -: CHAN_BITS]};
          end_color_r   <= {end_color_r[COLOR_BITS-CHAN_BITS-1:0],
                            end_color_r[COLOR_BITS-1 -: CHAN_BITS]};
          if (ch_r == CH_W'(NUM_CHAN - 1)) begin
            if (step_count_r < line_length_r) begin
              step_count_r <= step_count_r + LEN_BITS'(1);
            end
            state_r <= S_DONE;
          end else begin
            ch_r    <= ch_r + CH_W'(1);
            state_r <= S_MUL;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_pixel_color_r <= result_r;
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_pixel_color_r;

  `LCGS_ASSERT(a_count_le_len, step_count_r <= line_length_r, "step count past line length")
  `LCGS_ASSERT(a_units_exclusive, !(mul_st.busy && div_st.busy), "multiplier and divider overlap")
  `LCGS_ASSERT_IMP(a_quot_bound, div_st.done, quot <= mag, "quotient exceeds channel delta")
  `LCGS_ASSERT_NXT(a_zero_len, zero_len_step, state_r == S_DONE, "zero-length step not bypassed")

endmodule
